[sv/phase_current_peak_average_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the phase current peak average block
// Implication checks sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PHASE_CURRENT_PEAK_AVERAGE_ASSERT_SVH
`define PHASE_CURRENT_PEAK_AVERAGE_ASSERT_SVH

// same-cycle implication
`define PCPA_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pcpa: assertion failed");

// next-cycle implication
`define PCPA_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pcpa: assertion failed");

`endif

[sv/pcpa_pkg.sv]
// ----------------------------------------------------------------------------
// pcpa_pkg
// Types and constants shared by the phase current peak average block.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int RAW_W       = 12;
  localparam int ADC_BITS    = 12;
  localparam int PEAK_W      = 13;
  localparam int TOTAL_OUT_W = 21;
  localparam int AVG_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int PEAK_MAX    = 8190;
  localparam int WINDOW_DEF  = 200;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RAW_W-1:0]  ADC_MASK =
    (ADC_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << ADC_BITS) - 1);
  localparam logic [RAW_W-1:0]  OFFSET_RESET = 12'd2059;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd1966;
  localparam logic [AVG_W-1:0]  AVG_MAX      = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADC_OFFSET = 2'd0,
    CFG_MA_GAIN    = 2'd1
  } cfg_idx_t;

  typedef logic [PEAK_W-1:0] peak_t;

  typedef struct packed {
    logic [RAW_W-1:0] phase_a_raw;
    logic [RAW_W-1:0] phase_b_raw;
  } pcpa_in_t;

  typedef struct packed {
    logic [PEAK_W-1:0]      peak_counts;
    logic [TOTAL_OUT_W-1:0] window_total;
    logic [AVG_W-1:0]       average_ma;
  } pcpa_out_t;

  typedef struct packed {
    logic  valid;
    peak_t peak;
  } q_head_t;

endpackage

[sv/pcpa_ram.sv]
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module pcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/pcpa_front.sv]
// ----------------------------------------------------------------------------
// pcpa_front
// Input side: offset removal, third phase, peak magnitude, push to queue.
// ----------------------------------------------------------------------------
module pcpa_front import pcpa_pkg::*; (
  input  pcpa_in_t          in_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RAW_W-1:0]  adc_offset,
  input  logic              q_full,
  output logic              q_push,
  output peak_t             q_peak
);

  logic [RAW_W-1:0]        a_m, b_m, off_m;
  logic signed [RAW_W:0]   a_s, b_s;
  logic signed [RAW_W+1:0] sum_s;
  logic [RAW_W-1:0]        mag_a, mag_b;
  logic [RAW_W:0]          mag_c;
  logic [RAW_W-1:0]        mag_ab;

  always_comb begin
    a_m   = in_data.phase_a_raw & ADC_MASK;
    b_m   = in_data.phase_b_raw & ADC_MASK;
    off_m = adc_offset & ADC_MASK;
    a_s   = $signed({1'b0, a_m}) - $signed({1'b0, off_m});
    b_s   = $signed({1'b0, b_m}) - $signed({1'b0, off_m});
    sum_s = $signed({a_s[RAW_W], a_s}) + $signed({b_s[RAW_W], b_s});
    mag_a = a_s[RAW_W]   ? RAW_W'(-a_s)       : RAW_W'(a_s);
    mag_b = b_s[RAW_W]   ? RAW_W'(-b_s)       : RAW_W'(b_s);
    mag_c = sum_s[RAW_W+1] ? (RAW_W+1)'(-sum_s) : (RAW_W+1)'(sum_s);
    mag_ab = (mag_b > mag_a) ? mag_b : mag_a;
    q_peak = ({1'b0, mag_ab} >= mag_c) ? PEAK_W'(mag_ab) : PEAK_W'(mag_c);
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

[sv/pcpa_fifo.sv]
// ----------------------------------------------------------------------------
// pcpa_fifo
// Short queue of peaks between the front and back parts.
// ----------------------------------------------------------------------------
module pcpa_fifo import pcpa_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  peak_t   push_peak,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  peak_t          slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_peak;
    end
  end

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.peak  = slots_r[rd_ptr_r];

endmodule

[sv/pcpa_back.sv]
// ----------------------------------------------------------------------------
// pcpa_back
// Ring update and running total, then gain multiply into output register.
// ----------------------------------------------------------------------------
module pcpa_back import pcpa_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_head_t           head,
  output logic              pop,
  input  logic [GAIN_W-1:0] ma_gain_q16,
  output logic              out_valid,
  input  logic              out_ready,
  output pcpa_out_t         out_data
);

  `include "phase_current_peak_average_assert.svh"

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TOT_W  = $clog2(WINDOW * PEAK_MAX + 1);
  localparam int PROD_W = TOT_W + GAIN_W;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              fwd_hit_r;
  peak_t             fwd_data_r;
  peak_t             ram_rdata, old_peak;

  logic              s2_v_r;
  peak_t             s2_peak_r;
  logic [TOT_W-1:0]  s2_total_r;

  logic              out_valid_r;
  pcpa_out_t         out_data_r;

  logic              out_adv, s2_adv, slot_last;
  logic [PROD_W-1:0] prod;
  logic [TOT_W-1:0]  avg_full;
  logic [AVG_W-1:0]  avg;

  pcpa_ram #(
    .WIDTH (PEAK_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (pop),
    .waddr (slot_r),
    .wdata (head.peak),
    .raddr (slot_nxt),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_adv   = !out_valid_r || out_ready;
    s2_adv    = !s2_v_r || out_adv;
    pop       = head.valid && s2_adv;
    slot_last = (slot_r == SLOT_W'(WINDOW - 1));
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    if (pop) begin
      slot_nxt = slot_last ? '0 : slot_r + 1'b1;
      wrapped_nxt = wrapped_r || slot_last;
    end
    // unwritten entries read as zero until the first wrap
    old_peak  = wrapped_r ? (fwd_hit_r ? fwd_data_r : ram_rdata) : '0;
    total_nxt = pop ? total_r - TOT_W'(old_peak) + TOT_W'(head.peak) : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      wrapped_r   <= 1'b0;
      total_r     <= '0;
      fwd_hit_r   <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      total_r   <= total_nxt;
      fwd_hit_r <= pop && (slot_r == slot_nxt);
      if (s2_adv) begin
        s2_v_r <= pop;
      end
      if (out_adv) begin
        out_valid_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= head.peak;
    if (pop) begin
      s2_peak_r  <= head.peak;
      s2_total_r <= total_nxt;
    end
    if (out_adv && s2_v_r) begin
      out_data_r.peak_counts  <= s2_peak_r;
      out_data_r.window_total <= TOTAL_OUT_W'(s2_total_r);
      out_data_r.average_ma   <= avg;
    end
  end

  always_comb begin
    prod     = PROD_W'(s2_total_r) * PROD_W'(ma_gain_q16);
    avg_full = TOT_W'(prod >> GAIN_W);
    avg      = (32'(avg_full) > 32'(AVG_MAX)) ? AVG_MAX : AVG_W'(avg_full);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PCPA_ASSERT_NEXT(a_wrap_sticky, wrapped_r, wrapped_r)
  `PCPA_ASSERT_NEXT(a_s2_hold, s2_v_r && !out_adv, s2_v_r && $stable(s2_total_r))
  `PCPA_ASSERT_IMP(a_total_covers_old, pop, TOT_W'(old_peak) <= total_r)

endmodule

[sv/phase_current_peak_average.sv]
// ----------------------------------------------------------------------------
// phase_current_peak_average
// Peak three-phase current with a moving-window total and average in mA.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries two raw phase ADC codes.
// The offset is removed, the third phase is the negated sum, and the largest
// magnitude of the three is the item's peak. Result channel out_valid/
// out_ready/out_data gives the peak, the sum of the last WINDOW peaks and
// (total * gain) >> 16 saturated at 65535, one result per input item.
// cfg_we/cfg_index/cfg_wdata write adc_offset (0) and ma_gain_q16 (1).
// Throughput: one item per cycle unless out_ready stalls; the ring is a RAM
// whose read for the next slot is issued ahead, so each item costs one RAM
// write. An item reaches out_valid via the queue, s2 and output registers.
// Reset: offset 2059, gain 1966, running total and write slot zero; ring
// entries read as zero until the first wrap, so no clearing pass is needed.
// A stalled receiver holds the output register, backs up the pipeline and
// a two-entry queue, then drops in_ready.
// ----------------------------------------------------------------------------
module phase_current_peak_average import pcpa_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pcpa_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pcpa_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [RAW_W-1:0]  adc_offset_r;
  logic [GAIN_W-1:0] ma_gain_r;
  logic              q_full, q_push, q_pop;
  peak_t             q_peak;
  q_head_t           q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_offset_r <= OFFSET_RESET;
      ma_gain_r    <= GAIN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ADC_OFFSET) begin
        adc_offset_r <= cfg_wdata[RAW_W-1:0];
      end else if (cfg_index == CFG_MA_GAIN) begin
        ma_gain_r <= cfg_wdata[GAIN_W-1:0];
      end
    end
  end

  pcpa_front u_front (
    .in_data    (in_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_offset (adc_offset_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_peak     (q_peak)
  );

  pcpa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_peak (q_peak),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  pcpa_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .pop         (q_pop),
    .ma_gain_q16 (ma_gain_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
